// File: rtl/window_deviation_detector_top_assert.svh
// assertion macros for the window deviation detector
`ifndef WINDOW_DEVIATION_DETECTOR_TOP_ASSERT_SVH
`define WINDOW_DEVIATION_DETECTOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WDD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wdd_pkg.sv
package wdd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int THR_W    = 23;
    localparam int EV_W     = 2;

    localparam logic [THR_W-1:0] THR_RESET = 23'd13107;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_DETECT  = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic            bite_active;
        logic [EV_W-1:0] event_res;
        logic            sample_used;
    } t_out_item;

    // control from the sequencer to the statistics unit
    typedef struct packed {
        logic first;
        logic step;
        logic mul;
    } t_acc_ctl;

endpackage

// File: rtl/wdd_cell.sv
module wdd_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic signed [wdd_pkg::SAMPLE_W-1:0] i_value,
    output logic signed [wdd_pkg::SAMPLE_W-1:0] o_value
);
    import wdd_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value;

    // one window entry, takes the neighbor's value when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_en) begin
            r_value <= i_value;
        end
    end

    assign o_value = r_value;

endmodule

// File: rtl/wdd_acc.sv
module wdd_acc #(
    parameter int WINDOW = 10
) (
    input  logic                                i_clk,
    input  wdd_pkg::t_acc_ctl                   i_ctl,
    input  logic signed [wdd_pkg::SAMPLE_W-1:0] i_value,
    input  logic [wdd_pkg::THR_W-1:0]           i_thr,
    output logic                                o_deviates
);
    import wdd_pkg::*;

    localparam int EXT_W = SAMPLE_W + $clog2(WINDOW) + 3;
    localparam logic signed [EXT_W-1:0] WIN_S = EXT_W'(WINDOW);

    logic signed [EXT_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [EXT_W-1:0]    r_lo_x;
    logic signed [EXT_W-1:0]    r_hi_x;
    logic signed [EXT_W-1:0]    r_span;

    logic signed [EXT_W-1:0] w_value_ext;
    logic signed [EXT_W-1:0] w_min_ext;
    logic signed [EXT_W-1:0] w_max_ext;
    logic signed [EXT_W-1:0] w_thr_ext;

    assign w_value_ext = {{(EXT_W-SAMPLE_W){i_value[SAMPLE_W-1]}}, i_value};
    assign w_min_ext   = {{(EXT_W-SAMPLE_W){r_min[SAMPLE_W-1]}}, r_min};
    assign w_max_ext   = {{(EXT_W-SAMPLE_W){r_max[SAMPLE_W-1]}}, r_max};
    assign w_thr_ext   = {{(EXT_W-THR_W){1'b0}}, i_thr};

    // sum, minimum and maximum over the entries leaving the chain tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.first) begin
            r_sum <= w_value_ext;
            r_min <= i_value;
            r_max <= i_value;
        end else if (i_ctl.step) begin
            r_sum <= r_sum + w_value_ext;
            if (i_value < r_min) begin
                r_min <= i_value;
            end
            if (i_value > r_max) begin
                r_max <= i_value;
            end
        end
    end

    // scale extremes and threshold by the window length
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_lo_x <= WIN_S * w_min_ext;
            r_hi_x <= WIN_S * w_max_ext;
            r_span <= WIN_S * w_thr_ext;
        end
    end

    // deviation test against the window mean, scaled by the window length
    assign o_deviates = (r_lo_x < (r_sum - r_span)) || (r_hi_x > (r_sum + r_span));

endmodule

// File: rtl/window_deviation_detector_top.sv
// Window deviation detector. A sample transaction (req_type 0) or a restart
// transaction (req_type 1) gives exactly one result transaction. Restarts and
// samples consumed silently during warm-up or drop go from the accept cycle
// straight to the output cycle. A sample that enters the window passes the
// accept cycle, one full rotation of the row of window cells past the
// statistics unit, a multiply step, a compare step and the output cycle. A
// stalled output holds the output cycle until the stall clears. The
// threshold register resets to 0.2 (13107) and may be written only while no
// transaction is in flight.
`include "window_deviation_detector_top_assert.svh"

module window_deviation_detector_top #(
    parameter int WINDOW = 10,
    parameter int WARMUP = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  wdd_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output wdd_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_we,
    input  logic [wdd_pkg::THR_W-1:0]    i_cfg_data
);
    import wdd_pkg::*;

    localparam int CNT_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int WCNT_W = $clog2(WARMUP + 2);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // detector phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_WARM  = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_DROP  = 2'd3;

    logic [2:0]        r_state,  n_state;
    logic [1:0]        r_phase,  n_phase;
    logic [WCNT_W-1:0] r_warm,   n_warm;
    logic [WCNT_W-1:0] r_quiet,  n_quiet;
    logic              r_active, n_active;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    t_out_item         r_res,    n_res;
    logic [THR_W-1:0]  r_thr;
    logic              r_out_valid;
    t_out_item         r_out;

    logic                       w_accept;
    logic                       w_shift;
    logic                       w_chain_en;
    logic                       w_deviates;
    logic                       w_out_free;
    logic [WCNT_W-1:0]          w_warm_inc;
    logic [WCNT_W-1:0]          w_quiet_inc;
    logic signed [SAMPLE_W-1:0] w_head;
    logic signed [SAMPLE_W-1:0] w_cell [WINDOW];
    t_acc_ctl                   w_acc_ctl;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_shift     = w_accept && !i_in_data.req_type && (r_phase == PH_RUN);
    assign w_chain_en  = w_shift || (r_state == S_ROT);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_warm_inc  = r_warm + 1'b1;
    assign w_quiet_inc = r_quiet + 1'b1;

    // new sample enters at the head, otherwise the tail wraps around
    assign w_head = w_shift ? i_in_data.sample : w_cell[WINDOW-1];

    // row of window cells
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        wdd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_chain_en),
            .i_value ((k == 0) ? w_head : w_cell[(k == 0) ? 0 : k-1]),
            .o_value (w_cell[k])
        );
    end

    assign w_acc_ctl.first = (r_state == S_ROT) && (r_cnt == '0);
    assign w_acc_ctl.step  = (r_state == S_ROT);
    assign w_acc_ctl.mul   = (r_state == S_MUL);

    wdd_acc #(
        .WINDOW (WINDOW)
    ) u_acc (
        .i_clk      (i_clk),
        .i_ctl      (w_acc_ctl),
        .i_value    (w_cell[WINDOW-1]),
        .i_thr      (r_thr),
        .o_deviates (w_deviates)
    );

    // sequencer and detector phase logic
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_warm   = r_warm;
        n_quiet  = r_quiet;
        n_active = r_active;
        n_cnt    = r_cnt;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res.bite_active = r_active;
                    n_res.event_res   = EV_NONE;
                    n_res.sample_used = 1'b0;
                    n_state           = S_EMIT;
                    if (i_in_data.req_type) begin
                        n_phase = PH_START;
                    end else begin
                        unique case (r_phase)
                            PH_START: begin
                                n_warm  = '0;
                                n_phase = PH_WARM;
                            end
                            PH_WARM: begin
                                n_warm = w_warm_inc;
                                if (w_warm_inc >= WCNT_W'(WARMUP)) begin
                                    n_phase = PH_RUN;
                                end
                            end
                            PH_RUN: begin
                                n_cnt   = '0;
                                n_state = S_ROT;
                            end
                            default: begin
                                n_phase = PH_RUN;
                            end
                        endcase
                    end
                end
            end
            S_ROT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WINDOW - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_res.sample_used = 1'b1;
                n_res.event_res   = EV_NONE;
                if (w_deviates) begin
                    n_quiet = '0;
                    if (!r_active) begin
                        n_active        = 1'b1;
                        n_res.event_res = EV_DETECT;
                    end
                end else begin
                    if (r_active) begin
                        n_active        = 1'b0;
                        n_res.event_res = EV_RELEASE;
                    end
                    if (w_quiet_inc > WCNT_W'(WARMUP)) begin
                        n_quiet = '0;
                        n_phase = PH_DROP;
                    end else begin
                        n_quiet = w_quiet_inc;
                    end
                end
                n_res.bite_active = n_active;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_START;
            r_warm   <= '0;
            r_quiet  <= '0;
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_warm   <= n_warm;
            r_quiet  <= n_quiet;
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `WDD_ASSERT_NEXT(a_accept_busy, w_accept, r_state != S_IDLE, "accepted transaction left sequencer idle")
    `WDD_ASSERT_SAME(a_detect_active, o_out_valid && (o_out_data.event_res == EV_DETECT), o_out_data.bite_active, "detect event without activity")
    `WDD_ASSERT_SAME(a_release_quiet, o_out_valid && (o_out_data.event_res == EV_RELEASE), !o_out_data.bite_active, "release event while active")
    `WDD_ASSERT_SAME(a_silent_no_event, o_out_valid && !o_out_data.sample_used, o_out_data.event_res == EV_NONE, "event on a silent transaction")

endmodule
